@@ design/lcas_pkg.sv @@
// ----------------------------------------------------------------------------
// LED cube animation sequencer package
// Command codes, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package lcas_pkg;

  localparam int CMD_W    = 2;
  localparam int KEY_W    = 4;
  localparam int ANIM_W   = 4;
  localparam int SLOT_W   = 6;
  localparam int WORD_W   = 64;
  localparam int REP_W    = 8;
  localparam int DELAY_W  = WORD_W - REP_W;
  localparam int CNT_W    = 5;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 80;

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_KEY   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

  localparam logic [KEY_W-1:0] POWER_KEY   = 4'd12;
  localparam logic [CNT_W-1:0] CNT_DEFAULT = 5'd16;
  localparam logic [REP_W-1:0] REP_MAX     = 8'hFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_NEXT,
    ST_LOAD,
    ST_EMIT
  } lcas_state_t;

endpackage

@@ design/led_cube_animation_sequencer.sv @@
// ----------------------------------------------------------------------------
// LED cube animation sequencer
// Plays 64-LED frame animations stored in an on-chip table.
// ----------------------------------------------------------------------------
// Input stream: in_tuser carries the command (tick, key press, table write),
// in_tdata carries key, table address and table word. Every accepted input
// transaction produces exactly one output transaction with the LED pattern,
// the power state, and the current animation and frame numbers.
// The frame table sits in one synchronous RAM with one read port, so an item
// makes its reads one after another: a table write, a no-op, an ignored key
// or a tick while off reads nothing, a key press reads frame 1, and a tick
// reads the header and, when the frame changes, the next frame, frame 1 of
// the animation it wraps to, or the next frame and then that frame 1.
// The pattern of the current frame is held in a register and kept coherent
// with table writes, so only state changes need a read.
// Results wait in an output register; the next item is accepted while a
// result is pending and runs until it has to hand over its own result.
// A stalled receiver therefore stalls at most one item behind it.
// Reset (synchronous, rst_n low) restores animation 0, frame 1, power on and
// anim_count 16; the table keeps its contents and must be written before use.
// The user writes anim_count via cfg_we/cfg_wdata only while idle; unchecked.
// ----------------------------------------------------------------------------
module led_cube_animation_sequencer
  import lcas_pkg::*;
#(
  parameter int NUM_ANIMS   = 16,
  parameter int FRAME_SLOTS = 40,
  parameter int LOCKOUT_MS  = 500
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // key[3:0], table_anim[7:4], table_slot[13:8], table_word[77:14], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // cmd[1:0]
  input  logic [CMD_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // pattern[63:0], cube_on[64], anim_index[68:65], frame_index[74:69], zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CNT_W-1:0]      cfg_wdata
);

  localparam int DEPTH  = NUM_ANIMS * FRAME_SLOTS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int TGL_W  = $clog2(LOCKOUT_MS + 1);

  function automatic logic [ADDR_W-1:0] tbl_addr(input logic [ANIM_W-1:0] a,
                                                 input logic [SLOT_W-1:0] s);
    return ADDR_W'(32'(a) * FRAME_SLOTS + 32'(s));
  endfunction

  // Input field unpacking.
  logic [KEY_W-1:0]  in_key;
  logic [ANIM_W-1:0] in_anim;
  logic [SLOT_W-1:0] in_slot;
  logic [WORD_W-1:0] in_word;

  assign in_key  = in_tdata[3:0];
  assign in_anim = in_tdata[7:4];
  assign in_slot = in_tdata[13:8];
  assign in_word = in_tdata[77:14];

  lcas_state_t         state_r, state_nxt;
  logic [ANIM_W-1:0]   anim_r, anim_nxt;
  logic [SLOT_W-1:0]   frame_r, frame_nxt;
  logic [REP_W-1:0]    rep_r, rep_nxt;
  logic [REP_W-1:0]    lim_r, lim_nxt;
  logic [DELAY_W-1:0]  ms_r, ms_nxt;
  logic [TGL_W-1:0]    tgl_r, tgl_nxt;
  logic                run_r, run_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic [WORD_W-1:0]   pat_r, pat_nxt;
  logic                rd_oob_r, rd_oob_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                ram_we;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [WORD_W-1:0]   ram_q;
  logic [WORD_W-1:0]   rd_data;

  logic                emit;
  logic                in_accept;

  logic [SLOT_W:0]     frame_inc;
  logic [REP_W-1:0]    rep_inc;
  logic [ANIM_W-1:0]   anim_succ;
  logic [ANIM_W-1:0]   anim_adv;
  logic [ANIM_W-1:0]   key_sel;
  logic [ANIM_W-1:0]   key_anim;
  logic [REP_W-1:0]    lim_use;
  logic [REP_W-1:0]    wrap_rep;
  logic [ANIM_W-1:0]   wrap_anim;
  logic                wr_in_range;

  lcas_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_word),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // Animations beyond the table read as zero.
  assign rd_data = rd_oob_r ? '0 : ram_q;

  assign emit      = (state_r == ST_EMIT) && (!out_valid_r || out_tready);
  assign in_tready = (state_r == ST_IDLE) || emit;
  assign in_accept = in_tvalid && in_tready;

  assign frame_inc = {1'b0, frame_r} + 1'b1;
  assign rep_inc   = (rep_r == REP_MAX) ? rep_r : rep_r + 1'b1;
  assign anim_succ = anim_r + 1'b1;
  assign anim_adv  = ({1'b0, anim_succ} >= cnt_r) ? '0 : anim_succ;
  assign key_sel   = in_key - 1'b1;
  assign key_anim  = ({1'b0, key_sel} >= cnt_r) ? '0 : key_sel;
  assign lim_use   = (state_r == ST_HDR) ? rd_data[REP_W-1:0] : lim_r;

  // End of the frame list: count a repeat and move on once the limit is met.
  always_comb begin
    wrap_rep  = rep_inc;
    wrap_anim = anim_r;
    if (rep_inc >= lim_use) begin
      wrap_rep  = '0;
      wrap_anim = anim_adv;
    end
  end

  assign wr_in_range = ({1'b0, in_slot} < (SLOT_W + 1)'(FRAME_SLOTS)) &&
                       (32'(in_anim) < NUM_ANIMS);
  assign ram_waddr   = tbl_addr(in_anim, in_slot);

  always_comb begin
    state_nxt  = state_r;
    anim_nxt   = anim_r;
    frame_nxt  = frame_r;
    rep_nxt    = rep_r;
    lim_nxt    = lim_r;
    ms_nxt     = ms_r;
    tgl_nxt    = tgl_r;
    run_nxt    = run_r;
    pat_nxt    = pat_r;
    rd_oob_nxt = rd_oob_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = tbl_addr(anim_r, frame_r);

    case (state_r)
      ST_HDR: begin
        if (ms_r > rd_data[WORD_W-1:REP_W]) begin
          ms_nxt  = '0;
          lim_nxt = rd_data[REP_W-1:0];
          // A repeat count already at the limit moves on at any frame change.
          if (frame_inc < (SLOT_W + 1)'(FRAME_SLOTS) &&
              rep_r < rd_data[REP_W-1:0]) begin
            ram_re     = 1'b1;
            ram_raddr  = tbl_addr(anim_r, frame_inc[SLOT_W-1:0]);
            rd_oob_nxt = 32'(anim_r) >= NUM_ANIMS;
            state_nxt  = ST_NEXT;
          end else begin
            anim_nxt   = wrap_anim;
            rep_nxt    = wrap_rep;
            frame_nxt  = SLOT_W'(1);
            ram_re     = 1'b1;
            ram_raddr  = tbl_addr(wrap_anim, SLOT_W'(1));
            rd_oob_nxt = 32'(wrap_anim) >= NUM_ANIMS;
            state_nxt  = ST_LOAD;
          end
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_NEXT: begin
        if (rd_data == '0) begin
          anim_nxt   = wrap_anim;
          rep_nxt    = wrap_rep;
          frame_nxt  = SLOT_W'(1);
          ram_re     = 1'b1;
          ram_raddr  = tbl_addr(wrap_anim, SLOT_W'(1));
          rd_oob_nxt = 32'(wrap_anim) >= NUM_ANIMS;
          state_nxt  = ST_LOAD;
        end else begin
          frame_nxt = frame_inc[SLOT_W-1:0];
          pat_nxt   = rd_data;
          state_nxt = ST_EMIT;
        end
      end
      ST_LOAD: begin
        pat_nxt   = rd_data;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A new item is taken only from idle or while the previous one emits.
    if (in_accept) begin
      state_nxt = ST_EMIT;
      case (in_tuser)
        CMD_TICK: begin
          if (tgl_r < TGL_W'(LOCKOUT_MS)) begin
            tgl_nxt = tgl_r + 1'b1;
          end
          if (ms_r != '1) begin
            ms_nxt = ms_r + 1'b1;
          end
          if (run_r) begin
            ram_re     = 1'b1;
            ram_raddr  = tbl_addr(anim_r, '0);
            rd_oob_nxt = 32'(anim_r) >= NUM_ANIMS;
            state_nxt  = ST_HDR;
          end
        end
        CMD_KEY: begin
          if (in_key == POWER_KEY) begin
            if (tgl_r >= TGL_W'(LOCKOUT_MS)) begin
              tgl_nxt    = '0;
              run_nxt    = !run_r;
              frame_nxt  = SLOT_W'(1);
              ram_re     = 1'b1;
              ram_raddr  = tbl_addr(anim_r, SLOT_W'(1));
              rd_oob_nxt = 32'(anim_r) >= NUM_ANIMS;
              state_nxt  = ST_LOAD;
            end
          end else begin
            run_nxt    = 1'b1;
            anim_nxt   = key_anim;
            frame_nxt  = SLOT_W'(1);
            rep_nxt    = '0;
            ram_re     = 1'b1;
            ram_raddr  = tbl_addr(key_anim, SLOT_W'(1));
            rd_oob_nxt = 32'(key_anim) >= NUM_ANIMS;
            state_nxt  = ST_LOAD;
          end
        end
        CMD_WRITE: begin
          if (wr_in_range) begin
            ram_we = 1'b1;
            // Keep the held pattern coherent with the table.
            if (in_anim == anim_r && in_slot == frame_r) begin
              pat_nxt = in_word;
            end
          end
        end
        default: begin
          state_nxt = ST_EMIT;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      anim_r      <= '0;
      frame_r     <= SLOT_W'(1);
      rep_r       <= '0;
      ms_r        <= '0;
      tgl_r       <= '0;
      run_r       <= 1'b1;
      cnt_r       <= CNT_DEFAULT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      anim_r      <= anim_nxt;
      frame_r     <= frame_nxt;
      rep_r       <= rep_nxt;
      ms_r        <= ms_nxt;
      tgl_r       <= tgl_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cnt_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    lim_r    <= lim_nxt;
    pat_r    <= pat_nxt;
    rd_oob_r <= rd_oob_nxt;
    if (emit) begin
      out_data_r <= {5'd0, frame_r, anim_r, run_r, run_r ? pat_r : {WORD_W{1'b0}}};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ design/lcas_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lcas_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 640,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ test/led_cube_animation_sequencer_checker.sv @@
// ----------------------------------------------------------------------------
// LED cube animation sequencer checker
// Watches the input, result and register ports of the sequencer, keeps its own
// copy of the frame table and the playback state, works out the cube view that
// each accepted input transaction must produce and compares every result
// transaction with it, field by field.
// ----------------------------------------------------------------------------
module led_cube_animation_sequencer_checker
  import lcas_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [CMD_W-1:0]      in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CNT_W-1:0]      cfg_wdata,
  output int                    errors,
  output int                    pending
);

  localparam int ANIMS   = 16;
  localparam int SLOTS   = 40;
  localparam int LOCKOUT = 500;

  typedef struct packed {
    logic [WORD_W-1:0] pattern;
    logic              cube_on;
    logic [ANIM_W-1:0] anim;
    logic [SLOT_W-1:0] frame;
  } cube_view_t;

  logic [WORD_W-1:0]  frames [0:ANIMS*SLOTS-1];
  logic [ANIM_W-1:0]  cur_anim;
  int                 cur_frame;
  int                 reps;
  logic [DELAY_W-1:0] since_frame;
  int                 since_toggle;
  bit                 powered;
  logic [CNT_W-1:0]   anim_limit;
  cube_view_t         due_views[$];
  int                 err_cnt = 0;

  initial begin
    for (int i = 0; i < ANIMS * SLOTS; i++) frames[i] = '0;
    errors  = 0;
    pending = 0;
  end

  function automatic logic [WORD_W-1:0] frame_word(int a, int s);
    return frames[a * SLOTS + s];
  endfunction

  task automatic restart_at(int a);
    a = a & 15;
    if (a >= anim_limit) a = 0;
    cur_anim  = ANIM_W'(a);
    cur_frame = 1;
    reps      = 0;
  endtask

  task automatic ms_tick();
    logic [WORD_W-1:0] hdr;
    int                nxt;
    if (since_toggle < LOCKOUT) since_toggle++;
    if (since_frame != '1) since_frame++;
    if (powered) begin
      hdr = frame_word(cur_anim, 0);
      if (since_frame > hdr[WORD_W-1:REP_W]) begin
        since_frame = '0;
        nxt = cur_frame + 1;
        // Past the last slot or at a blank pattern the animation wraps to frame 1 and counts a repeat.
        if (nxt >= SLOTS || frame_word(cur_anim, nxt) == '0) begin
          nxt = 1;
          if (reps < 255) reps++;
        end
        cur_frame = nxt;
        if (reps >= hdr[REP_W-1:0]) restart_at(cur_anim + 1);
      end
    end
  endtask

  task automatic key_press(logic [KEY_W-1:0] k);
    if (k == POWER_KEY) begin
      // The power key is dead until the lockout has run out.
      if (since_toggle >= LOCKOUT) begin
        since_toggle = 0;
        powered      = !powered;
        cur_frame    = 1;
      end
    end else begin
      powered = 1'b1;
      restart_at((k + 15) & 15);
    end
  endtask

  task automatic check_field(string what, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin : watch
    cube_view_t seen;
    cube_view_t want;
    if (!rst_n) begin
      cur_anim     = '0;
      cur_frame    = 1;
      reps         = 0;
      since_frame  = '0;
      since_toggle = 0;
      powered      = 1'b1;
      anim_limit   = CNT_DEFAULT;
      due_views.delete();
    end else begin
      // A result accepted at this edge always belongs to an earlier transaction.
      if (out_tvalid && out_tready) begin
        seen.pattern = out_tdata[63:0];
        seen.cube_on = out_tdata[64];
        seen.anim    = out_tdata[68:65];
        seen.frame   = out_tdata[74:69];
        if (due_views.size() == 0) begin
          $display("%0t: result mismatch, expected nothing, actual %h", $time, out_tdata);
          err_cnt++;
        end else begin
          want = due_views.pop_front();
          check_field("pattern", want.pattern, seen.pattern);
          check_field("cube_on", want.cube_on, seen.cube_on);
          check_field("anim_index", want.anim, seen.anim);
          check_field("frame_index", want.frame, seen.frame);
        end
      end
      if (cfg_we) anim_limit = cfg_wdata;
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          CMD_TICK:  ms_tick();
          CMD_KEY:   key_press(in_tdata[3:0]);
          CMD_WRITE: begin
            if (in_tdata[13:8] < SLOTS)
              frames[in_tdata[7:4] * SLOTS + in_tdata[13:8]] = in_tdata[77:14];
          end
          default: ;
        endcase
        want.pattern = powered ? frame_word(cur_anim, cur_frame) : '0;
        want.cube_on = powered;
        want.anim    = cur_anim;
        want.frame   = cur_frame[SLOT_W-1:0];
        due_views.push_back(want);
      end
    end
    errors  <= err_cnt;
    pending <= due_views.size();
  end

endmodule

@@ test/led_cube_animation_sequencer_tb.sv @@
// ----------------------------------------------------------------------------
// LED cube animation sequencer testbench
// Fills the whole frame table, runs a short directed sequence over every key
// and command, then random ticks, keys and table rewrites under several
// animation counts, with random stalls on both streams. The checker module
// predicts and compares; this module drives stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module led_cube_animation_sequencer_tb;
  import lcas_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata  = '0;
  logic [CMD_W-1:0]      in_tuser  = '0;
  logic                  out_tready = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CNT_W-1:0]      cfg_wdata = '0;
  wire                   in_tready;
  wire                   out_tvalid;
  wire [OUT_DATA_W-1:0]  out_tdata;
  int                    errors;
  int                    pending;
  int                    cycles = 0;
  bit                    calm   = 1'b0;

  led_cube_animation_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  led_cube_animation_sequencer_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .errors     (errors),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) out_tready <= calm || ($urandom_range(0, 99) >= 31);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_in(logic [KEY_W-1:0] k, logic [ANIM_W-1:0] a,
                                                   logic [SLOT_W-1:0] s, logic [WORD_W-1:0] w);
    return {2'b00, w, s, a, k};
  endfunction

  function automatic logic [WORD_W-1:0] rand_pattern();
    logic [WORD_W-1:0] w;
    w = {$urandom, $urandom};
    if (w == '0) w = 64'd1;
    return w;
  endfunction

  // Mostly short delays and few repeats so that animations really advance.
  function automatic logic [WORD_W-1:0] rand_header();
    logic [DELAY_W-1:0] delay;
    logic [REP_W-1:0]   limit;
    int                 pick;
    pick  = $urandom_range(0, 15);
    delay = DELAY_W'((pick == 0) ? $urandom_range(4, 40) : $urandom_range(0, 3));
    if (pick == 2) delay = '1;
    limit = (pick == 1) ? REP_MAX : REP_W'($urandom_range(0, 3));
    return {delay, limit};
  endfunction

  function automatic logic [IN_DATA_W-1:0] rand_fields();
    return pack_in(KEY_W'($urandom), ANIM_W'($urandom), SLOT_W'($urandom),
                   {$urandom, $urandom});
  endfunction

  // Called right after the clock rises; returns once in_tready shows the transaction accepted.
  task automatic push_item(logic [CMD_W-1:0] cmd, logic [IN_DATA_W-1:0] data);
    while (!calm && $urandom_range(0, 99) < 31) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic push_write(int a, int s, logic [WORD_W-1:0] w);
    push_item(CMD_WRITE, pack_in(KEY_W'($urandom), ANIM_W'(a), SLOT_W'(s), w));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_anim_count(logic [CNT_W-1:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_random(int n, bit hold_midway);
    int                pick;
    int                s;
    logic [KEY_W-1:0]  k;
    logic [WORD_W-1:0] w;
    for (int i = 0; i < n; i++) begin
      if (hold_midway && i == n / 2) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 66) begin
        push_item(CMD_TICK, rand_fields());
      end else if (pick < 75) begin
        k = ($urandom_range(0, 9) < 4) ? POWER_KEY : KEY_W'($urandom_range(0, 15));
        push_item(CMD_KEY, pack_in(k, ANIM_W'($urandom), SLOT_W'($urandom),
                                   {$urandom, $urandom}));
      end else if (pick < 96) begin
        if ($urandom_range(0, 11) == 0) s = $urandom_range(40, 63);
        else if ($urandom_range(0, 6) == 0) s = 0;
        else s = $urandom_range(1, 39);
        if (s == 0) w = rand_header();
        else w = ($urandom_range(0, 9) == 0) ? '0 : rand_pattern();
        push_write($urandom_range(0, 15), s, w);
      end else begin
        push_item(CMD_NOP, rand_fields());
      end
    end
  endtask

  initial begin : stimulus
    int len;
    logic [WORD_W-1:0] w;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every table entry is written before playback can read it. The shown frame
    // of animation 0 goes first since each result already reads it.
    push_write(0, 1, rand_pattern());
    for (int a = 0; a < 16; a++) begin
      len = ($urandom_range(0, 3) == 0) ? 39 : $urandom_range(1, 38);
      for (int s = 0; s < 40; s++) begin
        if (s == 0) w = rand_header();
        else if (s <= len) w = rand_pattern();
        else if (s == len + 1) w = '0;
        else w = {$urandom, $urandom};
        if (!(a == 0 && s == 1)) push_write(a, s, w);
      end
    end

    // Directed: no-op, extreme words, ignored slots, every key value.
    push_item(CMD_NOP, rand_fields());
    push_write(15, 39, '1);
    push_write(0, 63, '1);
    push_write(3, 40, {$urandom, $urandom});
    repeat (3) push_item(CMD_TICK, '0);
    for (int k = 0; k < 16; k++) push_item(CMD_KEY, pack_in(KEY_W'(k), '1, '1, '1));
    repeat (2) push_item(CMD_TICK, rand_fields());

    set_anim_count(CNT_DEFAULT);
    run_random(250, 1'b1);
    set_anim_count(5'd1);
    run_random(150, 1'b0);
    set_anim_count(5'd0);
    run_random(100, 1'b0);
    set_anim_count(5'd9);
    calm <= 1'b1;
    run_random(250, 1'b0);
    calm <= 1'b0;
    set_anim_count(5'd31);
    run_random(100, 1'b0);
    set_anim_count(CNT_DEFAULT);
    run_random(150, 1'b0);

    wait_drained();
    repeat (12) @(posedge clk);
    if (errors == 0 && pending == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
design/lcas_pkg.sv
design/lcas_ram.sv
design/led_cube_animation_sequencer.sv
test/led_cube_animation_sequencer_checker.sv
test/led_cube_animation_sequencer_tb.sv
